// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: design/slct_pkg.sv
// ----------------------------------------------------------------------------
// slct_pkg
// Shared constants for the single-link cluster threshold block.
// ----------------------------------------------------------------------------
`default_nettype none

package slct_pkg;
	localparam int MAX_POINTS    = 128;
	localparam int COORD_BITS    = 16;
	localparam int CFG_W         = 8;
	localparam logic [CFG_W-1:0] CLUSTER_RESET = 8'd2;
endpackage

`default_nettype wire

// File: design/slct_ram.sv
// ----------------------------------------------------------------------------
// slct_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module slct_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

`default_nettype wire

// File: design/single_link_cluster_threshold.sv
// ----------------------------------------------------------------------------
// single_link_cluster_threshold
// Loads 2-D points, grows a minimum spanning tree Prim style, and reports the
// (k-1)-th largest tree edge with its square root in fixed point, 8 fraction bits.
// ----------------------------------------------------------------------------
// Loading takes one point per cycle while not busy; start may stay high.
// After the last point busy holds through Prim, the rank search, the square
// root and while the result is registered; a bad count strobes in the cycle
// after the last point. The receiver cannot stall.
// Reset clears control state; the first Prim step rewrites the tree flags.
`default_nettype none
`include "assert_macros.svh"

module single_link_cluster_threshold #(
	parameter int MAX_POINTS = slct_pkg::MAX_POINTS,
	parameter int COORD_BITS = slct_pkg::COORD_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [COORD_BITS-1:0]  point_x,
	input  wire logic signed [COORD_BITS-1:0]  point_y,
	input  wire logic                          last_point,
	input  wire logic                          cfg_we,
	input  wire logic [slct_pkg::CFG_W-1:0]    cfg_wdata,
	output logic                               result_valid,
	output logic [2*COORD_BITS:0]              split_distance_squared,
	output logic [COORD_BITS+8:0]              split_distance,
	output logic                               bad_cluster_count
);
	localparam int IW   = $clog2(MAX_POINTS);
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int CB   = COORD_BITS;
	localparam int DW   = 2 * CB + 1;
	localparam int VW   = 2 * CB + 20;
	localparam int NI   = CB + 10;
	localparam int NIW  = $clog2(NI + 1);
	localparam int KW   = slct_pkg::CFG_W;
	localparam int CMPW = (CW > KW) ? CW + 1 : KW + 1;

	typedef enum logic [13:0] {
		S_IDLE    = 14'b00000000000001,
		S_PREP    = 14'b00000000000010,
		S_PREAD   = 14'b00000000000100,
		S_PWAIT   = 14'b00000000001000,
		S_EADDR   = 14'b00000000010000,
		S_EDIFF   = 14'b00000000100000,
		S_MX      = 14'b00000001000000,
		S_MY      = 14'b00000010000000,
		S_EUPD    = 14'b00000100000000,
		S_STEPEND = 14'b00001000000000,
		S_CREAD   = 14'b00010000000000,
		S_CSWP    = 14'b00100000000000,
		S_CCHK    = 14'b01000000000000,
		S_SQRT    = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [KW-1:0]       k_q;
	logic [CW-1:0]       total_q, n_q, i_q, j_q, step_q, rank_q, lt_q, le_q;
	logic [IW-1:0]       pick_q, min_idx_q;
	logic                first_q, min_v_q, pend_q, cwait_q, done_q;
	logic [CB-1:0]       px_q, py_q, dx_q, dy_q;
	logic [DW-1:0]       best_q, min_q, cand_q, sqx_q, sqy_q;
	logic [VW-1:0]       v_q, r_q, bit_q;
	logic [NIW-1:0]      it_q;

	// RAM ports; the link RAM carries the in-tree flag above the distance
	logic                 xy_we, best_we, edge_we;
	logic [IW-1:0]        xy_waddr, xy_raddr, best_addr, edge_raddr;
	logic [CB-1:0]        x_rdata, y_rdata;
	logic [DW:0]          best_rdata, best_wdata;
	logic [DW-1:0]        edge_rdata;

	slct_ram #(.WIDTH(CB), .DEPTH(MAX_POINTS)) u_x_ram (
		.clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(point_x),
		.raddr(xy_raddr), .rdata(x_rdata)
	);
	slct_ram #(.WIDTH(CB), .DEPTH(MAX_POINTS)) u_y_ram (
		.clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(point_y),
		.raddr(xy_raddr), .rdata(y_rdata)
	);
	slct_ram #(.WIDTH(DW + 1), .DEPTH(MAX_POINTS)) u_best_ram (
		.clk(clk), .we(best_we), .waddr(best_addr), .wdata(best_wdata),
		.raddr(best_addr), .rdata(best_rdata)
	);
	slct_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_edge_ram (
		.clk(clk), .we(edge_we), .waddr(step_q[IW-1:0]), .wdata(min_q),
		.raddr(edge_raddr), .rdata(edge_rdata)
	);

	logic accept, store_pt;
	logic [CW-1:0] n_new;
	logic [CMPW-1:0] k_ext, n_ext;
	logic bad_k;

	// hold busy while a finished result is being registered onto the outputs
	assign busy     = (state_q != S_IDLE) || done_q;
	assign accept   = start && !busy;
	assign store_pt = accept && (total_q < CW'(MAX_POINTS));
	assign n_new    = store_pt ? total_q + CW'(1) : total_q;
	assign k_ext    = CMPW'(k_q);
	assign n_ext    = CMPW'(n_new);
	assign bad_k    = (k_ext < CMPW'(2)) || (k_ext > n_ext);

	assign xy_we    = store_pt;
	assign xy_waddr = total_q[IW-1:0];
	assign xy_raddr = (state_q == S_PREAD) ? pick_q : i_q[IW-1:0];
	assign best_addr = (state_q == S_STEPEND) ? min_idx_q : i_q[IW-1:0];

	// squared distance of the current candidate to the newest tree point
	logic [DW-1:0] link_dist, new_best;
	assign link_dist  = sqx_q + sqy_q;
	assign new_best   = (first_q || link_dist < best_q) ? link_dist : best_q;
	assign best_we    = (state_q == S_EUPD) || (state_q == S_STEPEND);
	assign best_wdata = (state_q == S_STEPEND) ? {1'b1, min_q} : {1'b0, new_best};
	assign edge_we    = (state_q == S_STEPEND);
	assign edge_raddr = (state_q == S_CREAD) ? j_q[IW-1:0] : i_q[IW-1:0];

	// one multiplier, shared between the two squares
	logic [CB-1:0]   mul_a;
	logic [2*CB-1:0] mul_p;
	assign mul_a = (state_q == S_MX) ? dx_q : dy_q;
	assign mul_p = mul_a * mul_a;

	logic signed [CB:0] diff_x, diff_y, neg_x, neg_y;
	assign diff_x = {x_rdata[CB-1], x_rdata} - {px_q[CB-1], px_q};
	assign diff_y = {y_rdata[CB-1], y_rdata} - {py_q[CB-1], py_q};
	assign neg_x  = -diff_x;
	assign neg_y  = -diff_y;

	logic [VW-1:0] r_bit;
	assign r_bit = r_q + bit_q;

	logic [CW-1:0] edge_m;
	assign edge_m = n_q - CW'(1);

	logic [VW-1:0] rt_sum;
	assign rt_sum = r_q + VW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			k_q          <= slct_pkg::CLUSTER_RESET;
			total_q      <= '0;
			result_valid <= 1'b0;
			pend_q       <= 1'b0;
			cwait_q      <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_we) begin
				k_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (done_q) begin
						done_q                 <= 1'b0;
						result_valid           <= 1'b1;
						bad_cluster_count      <= 1'b0;
						split_distance_squared <= cand_q;
						split_distance         <= rt_sum[CB+9:1];
					end
					if (accept) begin
						total_q <= n_new;
						if (last_point) begin
							total_q <= '0;
							n_q     <= n_new;
							rank_q  <= CW'(n_ext - k_ext);
							if (bad_k) begin
								result_valid           <= 1'b1;
								bad_cluster_count      <= 1'b1;
								split_distance_squared <= '0;
								split_distance         <= '0;
							end else begin
								state_q <= S_PREP;
							end
						end
					end
				end
				S_PREP: begin
					pick_q       <= '0;
					first_q      <= 1'b1;
					step_q       <= '0;
					state_q      <= S_PREAD;
				end
				S_PREAD: begin
					min_v_q <= 1'b0;
					i_q     <= CW'(1);
					state_q <= S_PWAIT;
				end
				S_PWAIT: begin
					px_q    <= x_rdata;
					py_q    <= y_rdata;
					state_q <= S_EADDR;
				end
				S_EADDR: begin
					if (i_q == n_q) begin
						state_q <= S_STEPEND;
					end else begin
						state_q <= S_EDIFF;
					end
				end
				S_EDIFF: begin
					// skip points already in the tree; flags are stale on the first step
					if (!first_q && best_rdata[DW]) begin
						i_q     <= i_q + CW'(1);
						state_q <= S_EADDR;
					end else begin
						dx_q    <= diff_x[CB] ? neg_x[CB-1:0] : diff_x[CB-1:0];
						dy_q    <= diff_y[CB] ? neg_y[CB-1:0] : diff_y[CB-1:0];
						best_q  <= best_rdata[DW-1:0];
						state_q <= S_MX;
					end
				end
				S_MX: begin
					sqx_q   <= DW'(mul_p);
					state_q <= S_MY;
				end
				S_MY: begin
					sqy_q   <= DW'(mul_p);
					state_q <= S_EUPD;
				end
				S_EUPD: begin
					if (!min_v_q || new_best < min_q) begin
						min_q     <= new_best;
						min_idx_q <= i_q[IW-1:0];
						min_v_q   <= 1'b1;
					end
					i_q     <= i_q + CW'(1);
					state_q <= S_EADDR;
				end
				S_STEPEND: begin
					pick_q  <= min_idx_q;
					first_q <= 1'b0;
					step_q  <= step_q + CW'(1);
					if (step_q + CW'(1) == edge_m) begin
						j_q     <= '0;
						state_q <= S_CREAD;
					end else begin
						state_q <= S_PREAD;
					end
				end
				S_CREAD: begin
					cwait_q <= 1'b1;
					i_q     <= '0;
					lt_q    <= '0;
					le_q    <= '0;
					state_q <= S_CSWP;
				end
				S_CSWP: begin
					// first cycle latches the candidate, then count the sweep
					if (cwait_q) begin
						cwait_q <= 1'b0;
						cand_q  <= edge_rdata;
						pend_q  <= 1'b0;
					end else begin
						if (pend_q) begin
							if (edge_rdata < cand_q) lt_q <= lt_q + CW'(1);
							if (edge_rdata <= cand_q) le_q <= le_q + CW'(1);
						end
						if (i_q == edge_m) begin
							pend_q  <= 1'b0;
							state_q <= S_CCHK;
						end else begin
							pend_q <= 1'b1;
							i_q    <= i_q + CW'(1);
						end
					end
				end
				S_CCHK: begin
					if (lt_q <= rank_q && rank_q < le_q) begin
						v_q     <= VW'(cand_q) << 18;
						r_q     <= '0;
						bit_q   <= VW'(1) << (VW - 2);
						it_q    <= '0;
						state_q <= S_SQRT;
					end else begin
						j_q     <= j_q + CW'(1);
						state_q <= S_CREAD;
					end
				end
				S_SQRT: begin
					if (v_q >= r_bit) begin
						v_q <= v_q - r_bit;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					it_q  <= it_q + NIW'(1);
					if (it_q == NIW'(NI - 1)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_CLK(a_strobe_idle, result_valid |-> !busy, "result strobe while busy")
	`ASSERT_CLK(a_bad_zero, (result_valid && bad_cluster_count) |-> (split_distance_squared == '0), "bad count with nonzero distance")
	`ASSERT_CLK(a_busy_cause, $rose(busy) |-> $past(start && last_point), "busy without a last point")
	`ASSERT_CLK(a_step_pick, (state_q == S_STEPEND) |-> min_v_q, "step ended without a candidate")
endmodule

`default_nettype wire
